### src/ccl_pkg.sv
`timescale 1ns / 1ps

package ccl_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam int ROW_W         = 32;
    localparam int LABEL_W       = 6;
    localparam int IDX_IN_W      = 5;
    localparam int NNODES_W      = 6;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    // register index, taken from paddr[2]
    localparam logic REG_N_NODES = 1'b0;
    localparam logic [NNODES_W-1:0] N_NODES_RESET = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_SWEEP,
        ST_ASSIGN,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [LABEL_W-1:0] label;
    } cell_data_t;

    typedef struct packed {
        logic                load;
        logic [IDX_IN_W-1:0] load_idx;
        logic                shift;
        logic                clear;
        logic                label_wr;
        logic [LABEL_W-1:0]  label_val;
    } chain_ctl_t;

endpackage

### src/connected_component_labeler_core.sv
`timescale 1ns / 1ps

// Connected-component labeler. Each request writes one adjacency row;
// busy stays low while rows are loaded. The row marked last_row starts labeling:
// the rows sit in a ring of NUM cells that rotates one place a cycle past a single
// head cell while it sweeps, writes labels or outputs (NUM = min(MAX_NODES, 32)).
// For each node that starts a new component the ring makes one pass per frontier
// growth plus one quiet pass and one pass to write labels; already labeled nodes
// are skipped. Then n results follow back to back, n being the active node
// count, one per node in ascending order, each marked by result_valid for a
// single cycle; the receiver cannot stall them and must take every one. busy
// returns low on the cycle after the last result.

module connected_component_labeler_core
    import ccl_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [IDX_IN_W-1:0] row_index,
    input  logic [ROW_W-1:0]    neighbor_bits,
    input  logic                last_row,
    output logic                result_valid,
    output logic [IDX_IN_W-1:0] node_index,
    output logic [LABEL_W-1:0]  component_label,
    output logic [LABEL_W-1:0]  component_count,
    output logic                last_of_run
);

    localparam int NUM   = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
    localparam int IDX_W = $clog2(NUM);
    localparam int CNT_W = $clog2(NUM + 1);

    state_t state_reg;
    state_t state_next;

    logic [NNODES_W-1:0] n_nodes_reg;
    logic [CNT_W-1:0]    n_eff_reg,  n_eff_next;
    logic [CNT_W-1:0]    seed_reg,   seed_next;
    logic [IDX_W-1:0]    pos_reg,    pos_next;
    logic [NUM-1:0]      reach_reg,  reach_next;
    logic [NUM-1:0]      labeled_reg, labeled_next;
    logic                changed_reg, changed_next;
    logic [LABEL_W-1:0]  next_label_reg, next_label_next;

    logic                result_valid_reg, result_valid_next;
    logic [IDX_IN_W-1:0] node_index_reg,   node_index_next;
    logic [LABEL_W-1:0]  label_out_reg,    label_out_next;
    logic [LABEL_W-1:0]  count_out_reg,    count_out_next;
    logic                last_out_reg,     last_out_next;

    logic               accept;
    logic               cfg_write;
    logic [CNT_W-1:0]   n_clamp;
    logic [NUM-1:0]     active;
    logic [NUM-1:0]     new_bits;
    logic               grew;
    logic               pass_end;
    logic               out_end;
    logic [IDX_W-1:0]   last_pos;
    logic [IDX_W-1:0]   seed_idx;
    chain_ctl_t         ctl;
    cell_data_t         head;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_N_NODES)
                       ? {{(PDATA_W - NNODES_W){1'b0}}, n_nodes_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_nodes_reg <= N_NODES_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_N_NODES))
        begin
            n_nodes_reg <= pwdata[NNODES_W-1:0];
        end
    end

    // ---------------- helpers ----------------
    assign busy   = (state_reg != ST_IDLE) || result_valid_reg;
    assign accept = start && !busy;

    always_comb
    begin
        if (n_nodes_reg == '0)
        begin
            n_clamp = CNT_W'(1);
        end
        else if (n_nodes_reg > NNODES_W'(NUM))
        begin
            n_clamp = CNT_W'(NUM);
        end
        else
        begin
            n_clamp = CNT_W'(n_nodes_reg);
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM; j++)
        begin
            active[j] = (j < int'(n_eff_reg));
        end
    end

    assign seed_idx = seed_reg[IDX_W-1:0];
    assign last_pos = IDX_W'(n_eff_reg - CNT_W'(1));
    assign pass_end = (pos_reg == IDX_W'(NUM - 1));
    assign out_end  = (pos_reg == last_pos);
    assign new_bits = reach_reg[pos_reg]
                      ? (head.row[NUM-1:0] & active & ~labeled_reg & ~reach_reg) : '0;
    assign grew     = |new_bits;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_row)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                if (seed_reg == n_eff_reg)
                begin
                    state_next = ST_OUTPUT;
                end
                else if (!labeled_reg[seed_idx])
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (pass_end && !(changed_reg || grew))
                begin
                    state_next = ST_ASSIGN;
                end
            end
            ST_ASSIGN:
            begin
                if (pass_end)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_OUTPUT:
            begin
                if (out_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- chain control ----------------
    always_comb
    begin
        ctl           = '0;
        ctl.load      = accept;
        ctl.load_idx  = row_index;
        ctl.label_val = next_label_reg;
        unique case (state_reg)
            ST_IDLE, ST_SEED:
            begin
                ctl.shift = 1'b0;
            end
            ST_SWEEP:
            begin
                ctl.shift = 1'b1;
            end
            ST_ASSIGN:
            begin
                ctl.shift    = 1'b1;
                ctl.label_wr = reach_reg[pos_reg];
            end
            ST_OUTPUT:
            begin
                ctl.shift = 1'b1;
                ctl.clear = out_end;
            end
            default:
            begin
                ctl.shift = 1'b0;
            end
        endcase
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        n_eff_next        = n_eff_reg;
        seed_next         = seed_reg;
        pos_next          = pos_reg;
        reach_next        = reach_reg;
        labeled_next      = labeled_reg;
        changed_next      = changed_reg;
        next_label_next   = next_label_reg;
        result_valid_next = 1'b0;
        node_index_next   = node_index_reg;
        label_out_next    = label_out_reg;
        count_out_next    = count_out_reg;
        last_out_next     = last_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_row)
                begin
                    n_eff_next      = n_clamp;
                    seed_next       = '0;
                    pos_next        = '0;
                    labeled_next    = '0;
                    next_label_next = LABEL_W'(1);
                end
            end
            ST_SEED:
            begin
                pos_next = '0;
                if (seed_reg != n_eff_reg)
                begin
                    if (labeled_reg[seed_idx])
                    begin
                        seed_next = seed_reg + CNT_W'(1);
                    end
                    else
                    begin
                        reach_next           = '0;
                        reach_next[seed_idx] = 1'b1;
                        changed_next         = 1'b0;
                    end
                end
            end
            ST_SWEEP:
            begin
                reach_next = reach_reg | new_bits;
                if (pass_end)
                begin
                    pos_next     = '0;
                    changed_next = 1'b0;
                end
                else
                begin
                    pos_next     = pos_reg + IDX_W'(1);
                    changed_next = changed_reg || grew;
                end
            end
            ST_ASSIGN:
            begin
                if (pass_end)
                begin
                    pos_next        = '0;
                    labeled_next    = labeled_reg | reach_reg;
                    next_label_next = next_label_reg + LABEL_W'(1);
                    seed_next       = seed_reg + CNT_W'(1);
                end
                else
                begin
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
            ST_OUTPUT:
            begin
                result_valid_next = 1'b1;
                node_index_next   = IDX_IN_W'(pos_reg);
                label_out_next    = head.label;
                count_out_next    = next_label_reg - LABEL_W'(1);
                last_out_next     = out_end;
                pos_next          = pos_reg + IDX_W'(1);
            end
            default:
            begin
                pos_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            n_eff_reg        <= '0;
            seed_reg         <= '0;
            pos_reg          <= '0;
            reach_reg        <= '0;
            labeled_reg      <= '0;
            changed_reg      <= 1'b0;
            next_label_reg   <= LABEL_W'(1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            n_eff_reg        <= n_eff_next;
            seed_reg         <= seed_next;
            pos_reg          <= pos_next;
            reach_reg        <= reach_next;
            labeled_reg      <= labeled_next;
            changed_reg      <= changed_next;
            next_label_reg   <= next_label_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_index_reg <= node_index_next;
        label_out_reg  <= label_out_next;
        count_out_reg  <= count_out_next;
        last_out_reg   <= last_out_next;
    end

    ccl_chain #(
        .NUM_CELLS (NUM)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .load_row (neighbor_bits),
        .head     (head)
    );

    assign result_valid    = result_valid_reg;
    assign node_index      = node_index_reg;
    assign component_label = label_out_reg;
    assign component_count = count_out_reg;
    assign last_of_run     = last_out_reg;

endmodule

### src/ccl_cell.sv
`timescale 1ns / 1ps

module ccl_cell
    import ccl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             shift,
    input  logic             clear,
    input  logic [ROW_W-1:0] load_row,
    input  cell_data_t       shift_in,
    output cell_data_t       data
);

    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = shift_in;
        end
        if (load)
        begin
            data_next.row = load_row;
        end
        if (clear)
        begin
            data_next.row = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

### src/ccl_chain.sv
`timescale 1ns / 1ps

module ccl_chain
    import ccl_pkg::*;
#(
    parameter int NUM_CELLS = MAX_NODES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_ctl_t       ctl,
    input  logic [ROW_W-1:0] load_row,
    output cell_data_t       head
);

    cell_data_t data [NUM_CELLS];
    cell_data_t head_mod;

    // label is written as the head entry wraps round to the tail
    always_comb
    begin
        head_mod = data[0];
        if (ctl.label_wr)
        begin
            head_mod.label = ctl.label_val;
        end
    end

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        cell_data_t shift_in;
        logic       load_here;

        if (k == NUM_CELLS - 1)
        begin : g_tail
            assign shift_in = head_mod;
        end
        else
        begin : g_mid
            assign shift_in = data[k + 1];
        end

        assign load_here = ctl.load && (ctl.load_idx == IDX_IN_W'(k));

        ccl_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load_here),
            .shift    (ctl.shift),
            .clear    (ctl.clear),
            .load_row (load_row),
            .shift_in (shift_in),
            .data     (data[k])
        );
    end

    assign head = data[0];

endmodule

### src/ccl_checker.sv
`timescale 1ns / 1ps

module ccl_checker
    import ccl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                last_row,
    input logic                result_valid,
    input logic [LABEL_W-1:0]  component_label,
    input logic [LABEL_W-1:0]  component_count,
    input logic                last_of_run
);

    // no result may appear outside a labeling run
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside a run");

    // a plain row request must leave the block ready for the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_row) |=> !busy)
        else $error("busy after a plain row request");

    // results of a run come back to back until the one marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_run) |=> result_valid)
        else $error("gap inside a result run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_run) |=> !result_valid)
        else $error("result after the last of a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (component_label != '0) && (component_label <= component_count))
        else $error("label out of range");

endmodule

bind connected_component_labeler_core ccl_checker u_ccl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .last_row        (last_row),
    .result_valid    (result_valid),
    .component_label (component_label),
    .component_count (component_count),
    .last_of_run     (last_of_run)
);
